// ===== rtl/core/cfs_pkg.sv =====
// Package for the circular FIFO with search: payload widths, action and
// status codes, the response record and the cell control record.
// No dependencies; compile first.
package cfs_pkg;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 9;

    // Request kinds
    localparam logic [ACTION_W-1:0] ACT_ENQ    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQ    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [OCC_W-1:0]    occ_t;

    // One result item
    typedef struct packed {
        status_t status;
        value_t  front_value;
        logic    found;
        occ_t    occupancy;
        logic    is_empty;
    } rsp_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic shift;   // move each entry one cell toward the front
        logic load;    // write the new element into the cell at the back
    } cell_ctrl_t;

endpackage

// ===== rtl/core/cfs_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on cfs_pkg.
interface cfs_req_if;
    import cfs_pkg::*;

    logic    valid;
    logic    ready;
    action_t action;
    value_t  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface cfs_rsp_if;
    import cfs_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    value_t  front_value;
    logic    found;
    occ_t    occupancy;
    logic    is_empty;

    modport source (
        output valid, output status, output front_value, output found,
        output occupancy, output is_empty, input ready
    );
    modport sink (
        input valid, input status, input front_value, input found,
        input occupancy, input is_empty, output ready
    );
endinterface

// ===== rtl/core/circular_fifo_with_search.sv =====
// Top level of the circular FIFO with search: control sequencer, the chain
// of storage cells and the result buffer. Depends on cfs_pkg, cfs_if,
// cfs_cell and cfs_out_buf.
//
// The queue is a row of DEPTH cells with the front entry always in cell 0.
// Enqueue writes the cell just past the last entry, dequeue shifts every
// cell one place toward the front. Enqueue, dequeue, an unused action and a
// search of an empty queue hand their result item to the result buffer in
// the accepting cycle. A search of N stored entries rotates them through
// cell 0, where one comparator checks each entry: after the accepting
// cycle it takes one rotation step per entry, and the rotation always runs
// the full N steps so the order is restored when it ends. Two result items
// can wait at the output, and a new request is taken whenever the sequencer
// is idle and a result slot is free. The store needs no clearing after
// reset.
module circular_fifo_with_search #(
    parameter int DEPTH         = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    cfs_req_if.sink        req,
    cfs_rsp_if.source      rsp
);
    import cfs_pkg::*;

    localparam int W  = ELEMENT_WIDTH;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] rem_next;
    logic [W-1:0]  key_reg;
    logic [W-1:0]  key_next;
    logic          found_reg;
    logic          found_next;

    logic          accept;
    logic          buf_full;
    logic          push;
    rsp_t          push_data;
    rsp_t          out_data;
    cell_ctrl_t    ctrl;
    logic [CW-1:0] last;
    logic [W-1:0]  elem;
    logic [W-1:0]  cell_data [DEPTH];
    logic [VALUE_W-1:0] front_ext;
    occ_t          occ_next;
    logic          is_full;
    logic          is_zero;
    logic          hit;

    // Element width versus the fixed payload width
    generate
        if (W <= VALUE_W)
        begin : g_narrow
            assign elem      = req.value[W-1:0];
            assign front_ext = {{(VALUE_W - W){1'b0}}, cell_data[0]};
        end
        else
        begin : g_wide
            assign elem      = {{(W - VALUE_W){1'b0}}, req.value};
            assign front_ext = cell_data[0][VALUE_W-1:0];
        end
    endgenerate

    // Count versus the fixed occupancy width
    generate
        if (CW >= OCC_W)
        begin : g_occ_trunc
            assign occ_next = count_next[OCC_W-1:0];
        end
        else
        begin : g_occ_ext
            assign occ_next = {{(OCC_W - CW){1'b0}}, count_next};
        end
    endgenerate

    assign accept  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE) && !buf_full;
    assign is_full = (count_reg == CW'(DEPTH));
    assign is_zero = (count_reg == '0);
    assign last    = count_reg - CW'(1);
    assign hit     = (cell_data[0] == key_reg);

    // Sequence requests and drive the cell chain
    always_comb
    begin
        state_next            = state_reg;
        count_next            = count_reg;
        rem_next              = rem_reg;
        key_next              = key_reg;
        found_next            = found_reg;
        ctrl.shift            = 1'b0;
        ctrl.load             = 1'b0;
        push                  = 1'b0;
        push_data.status      = STS_DONE;
        push_data.front_value = '0;
        push_data.found       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.action)
                        ACT_ENQ:
                        begin
                            push = 1'b1;
                            if (is_full)
                            begin
                                push_data.status = STS_FULL;
                            end
                            else
                            begin
                                ctrl.load  = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_DEQ:
                        begin
                            push = 1'b1;
                            if (is_zero)
                            begin
                                push_data.status = STS_EMPTY;
                            end
                            else
                            begin
                                ctrl.shift            = 1'b1;
                                push_data.front_value = front_ext;
                                count_next            = count_reg - CW'(1);
                            end
                        end
                        ACT_SEARCH:
                        begin
                            if (is_zero)
                            begin
                                push = 1'b1;
                            end
                            else
                            begin
                                key_next   = elem;
                                rem_next   = count_reg;
                                found_next = 1'b0;
                                state_next = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            push = 1'b1;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                // Rotate one entry through the front comparator
                ctrl.shift = 1'b1;
                found_next = found_reg || hit;
                rem_next   = rem_reg - CW'(1);
                if (rem_reg == CW'(1))
                begin
                    push            = 1'b1;
                    push_data.found = found_reg || hit;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        push_data.occupancy = occ_next;
        push_data.is_empty  = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    // Chain of storage cells, front entry in cell 0
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [W-1:0] nbr;
            if (i < DEPTH - 1)
            begin : g_mid
                assign nbr = cell_data[i + 1];
            end
            else
            begin : g_end
                assign nbr = cell_data[0];
            end
            cfs_cell #(
                .W     (W),
                .CW    (CW),
                .INDEX (i)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .count     (count_reg),
                .last      (last),
                .wr_data   (elem),
                .wrap_data (cell_data[0]),
                .nbr_data  (nbr),
                .data      (cell_data[i])
            );
        end
    endgenerate

    // Result buffer
    cfs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (out_data)
    );

    assign rsp.status      = out_data.status;
    assign rsp.front_value = out_data.front_value;
    assign rsp.found       = out_data.found;
    assign rsp.occupancy   = out_data.occupancy;
    assign rsp.is_empty    = out_data.is_empty;

endmodule

// ===== rtl/core/cfs_cell.sv =====
// One storage cell of the queue chain: holds the entry at a fixed position
// and takes its neighbor's entry on a shift. Depends on cfs_pkg.
module cfs_cell #(
    parameter int W     = 32,
    parameter int CW    = 9,
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  cfs_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]       count,
    input  logic [CW-1:0]       last,
    input  logic [W-1:0]        wr_data,
    input  logic [W-1:0]        wrap_data,
    input  logic [W-1:0]        nbr_data,
    output logic [W-1:0]        data
);
    import cfs_pkg::*;

    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    // Take the neighbor on a shift; the back cell takes the front entry so
    // that a full rotation restores the order
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = (last == MY_INDEX) ? wrap_data : nbr_data;
        end
        else if (ctrl.load && (count == MY_INDEX))
        begin
            data_next = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/core/cfs_out_buf.sv =====
// Two-entry output buffer for result items: an output register plus a
// skid register, so a new item can finish while one waits. Depends on cfs_pkg.
module cfs_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cfs_pkg::rsp_t push_data,
    output logic          full,
    output logic          out_valid,
    input  logic          out_ready,
    output cfs_pkg::rsp_t out_data
);
    import cfs_pkg::*;

    logic out_vld_reg;
    logic out_vld_next;
    logic sk_vld_reg;
    logic sk_vld_next;
    rsp_t out_reg;
    rsp_t out_next;
    rsp_t sk_reg;
    rsp_t sk_next;
    logic pop;

    assign pop = out_vld_reg && out_ready;

    // Advance the skid into the output slot and take the new item
    always_comb
    begin
        out_vld_next = out_vld_reg;
        sk_vld_next  = sk_vld_reg;
        out_next     = out_reg;
        sk_next      = sk_reg;
        if (push)
        begin
            if (!out_vld_reg || pop)
            begin
                out_vld_next = 1'b1;
                if (sk_vld_reg)
                begin
                    out_next = sk_reg;
                    sk_next  = push_data;
                end
                else
                begin
                    out_next = push_data;
                end
            end
            else
            begin
                sk_vld_next = 1'b1;
                sk_next     = push_data;
            end
        end
        else if (pop)
        begin
            if (sk_vld_reg)
            begin
                out_next    = sk_reg;
                sk_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            sk_vld_reg  <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            sk_vld_reg  <= sk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        sk_reg  <= sk_next;
    end

    assign full      = sk_vld_reg;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

endmodule

// ===== sim/testbench.sv =====
// Testbench for circular_fifo_with_search: a directed table (with a fill to full),
// then random requests, about 650 items in all, checked against an in-bench queue model.
// Depends on cfs_pkg, cfs_if and the RTL of circular_fifo_with_search.
module testbench;
    import cfs_pkg::*;

    localparam int DEPTH          = 256;
    localparam int RANDOM_ITEMS   = 370;
    localparam int LONG_HOLD      = 200;
    localparam int HOLD_SPACING   = 560;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 16;

    // Action code that the block must treat as a no-op
    localparam action_t ACT_SPARE = 2'd3;

    typedef struct {
        action_t     act;
        value_t      val;
        int unsigned reps;
        bit          typed;
        rsp_t        want;
    } dir_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cfs_req_if req_ch ();
    cfs_rsp_if rsp_ch ();

    circular_fifo_with_search #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (VALUE_W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Queue model state
    value_t              q_store [DEPTH];
    logic [7:0]          q_head;
    logic [7:0]          q_tail;
    occ_t                q_count;
    value_t              last_removed;

    rsp_t                pending_results [$];
    bit                  gaps_enabled = 1'b1;
    int unsigned         error_count   = 0;
    int unsigned         items_sent    = 0;
    int unsigned         results_seen  = 0;
    int unsigned         full_refusals = 0;
    int unsigned         empty_refusals = 0;
    int unsigned         search_hits   = 0;

    // Directed rows: expectation typed in where it is obvious, else predicted
    dir_row_t directed_rows [] = '{
        '{ACT_DEQ,    32'h0000_0000, 1,   1'b1, '{STS_EMPTY, 32'h0, 1'b0, 9'd0, 1'b1}},
        '{ACT_SEARCH, 32'h0000_0000, 1,   1'b1, '{STS_DONE, 32'h0, 1'b0, 9'd0, 1'b1}},
        '{ACT_SPARE,  32'hFFFF_FFFF, 1,   1'b1, '{STS_DONE, 32'h0, 1'b0, 9'd0, 1'b1}},
        '{ACT_ENQ,    32'h0000_0000, 1,   1'b1, '{STS_DONE, 32'h0, 1'b0, 9'd1, 1'b0}},
        '{ACT_ENQ,    32'hFFFF_FFFF, 1,   1'b1, '{STS_DONE, 32'h0, 1'b0, 9'd2, 1'b0}},
        '{ACT_SEARCH, 32'hFFFF_FFFF, 1,   1'b1, '{STS_DONE, 32'h0, 1'b1, 9'd2, 1'b0}},
        '{ACT_SEARCH, 32'h0000_0000, 1,   1'b1, '{STS_DONE, 32'h0, 1'b1, 9'd2, 1'b0}},
        '{ACT_SEARCH, 32'h1234_5678, 1,   1'b1, '{STS_DONE, 32'h0, 1'b0, 9'd2, 1'b0}},
        '{ACT_DEQ,    32'h0000_0000, 1,   1'b1, '{STS_DONE, 32'h0, 1'b0, 9'd1, 1'b0}},
        // removed entry is still in the store but must not match
        '{ACT_SEARCH, 32'h0000_0000, 1,   1'b1, '{STS_DONE, 32'h0, 1'b0, 9'd1, 1'b0}},
        '{ACT_SPARE,  32'h0000_0000, 1,   1'b0, '0},
        '{ACT_DEQ,    32'h0000_0000, 1,   1'b1,
          '{STS_DONE, 32'hFFFF_FFFF, 1'b0, 9'd0, 1'b1}},
        '{ACT_DEQ,    32'hFFFF_FFFF, 1,   1'b1, '{STS_EMPTY, 32'h0, 1'b0, 9'd0, 1'b1}},
        // fill to full with counting values; the ring wraps on the way
        '{ACT_ENQ,    32'h1000_0000, 256, 1'b0, '0},
        '{ACT_ENQ,    32'hA5A5_A5A5, 1,   1'b1, '{STS_FULL, 32'h0, 1'b0, 9'd256, 1'b0}},
        '{ACT_SEARCH, 32'h1000_00FF, 1,   1'b1, '{STS_DONE, 32'h0, 1'b1, 9'd256, 1'b0}},
        '{ACT_SEARCH, 32'hA5A5_A5A5, 1,   1'b1, '{STS_DONE, 32'h0, 1'b0, 9'd256, 1'b0}},
        '{ACT_DEQ,    32'h0000_0000, 1,   1'b1,
          '{STS_DONE, 32'h1000_0000, 1'b0, 9'd255, 1'b0}},
        '{ACT_ENQ,    32'h5A5A_5A5A, 1,   1'b0, '0},
        '{ACT_SEARCH, 32'h1000_0000, 1,   1'b0, '0},
        '{ACT_SEARCH, 32'h5A5A_5A5A, 1,   1'b0, '0},
        '{ACT_SPARE,  32'h5A5A_5A5A, 1,   1'b0, '0}
    };

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_model();
        foreach (q_store[i])
        begin
            q_store[i] = '0;
        end
        q_head       = '0;
        q_tail       = 8'(DEPTH - 1);
        q_count      = '0;
        last_removed = '0;
    endfunction

    // Advance the queue model by one request and return its result item
    function automatic rsp_t apply_request(action_t act, value_t val);
        rsp_t        res;
        logic [7:0]  slot;
        res = '0;
        res.status = STS_DONE;
        case (act)
            ACT_ENQ:
            begin
                if (q_count == occ_t'(DEPTH))
                begin
                    res.status = STS_FULL;
                end
                else
                begin
                    q_tail          = q_tail + 8'd1;
                    q_store[q_tail] = val;
                    q_count         = q_count + 1'b1;
                end
            end
            ACT_DEQ:
            begin
                if (q_count == '0)
                begin
                    res.status = STS_EMPTY;
                end
                else
                begin
                    res.front_value = q_store[q_head];
                    last_removed    = q_store[q_head];
                    q_head          = q_head + 8'd1;
                    q_count         = q_count - 1'b1;
                end
            end
            ACT_SEARCH:
            begin
                slot = q_head;
                for (int n = 0; n < int'(q_count); n++)
                begin
                    if (q_store[slot] == val)
                    begin
                        res.found = 1'b1;
                        break;
                    end
                    slot = slot + 8'd1;
                end
            end
            default:
            begin
            end
        endcase
        res.occupancy = q_count;
        res.is_empty  = (q_count == '0);
        return res;
    endfunction

    // Mostly short gaps, a few long, none while gaps are switched off
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gaps_enabled || r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic value_t pick_element();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return 32'h0000_0000;
        end
        if (r < 20)
        begin
            return 32'hFFFF_FFFF;
        end
        if (r < 35)
        begin
            return value_t'($urandom_range(0, 7));
        end
        return value_t'($urandom);
    endfunction

    function automatic value_t pick_search_value();
        int unsigned r;
        logic [7:0]  slot;
        r = $urandom_range(0, 99);
        if (r < 50 && q_count != '0)
        begin
            slot = q_head + 8'($urandom_range(0, int'(q_count) - 1));
            return q_store[slot];
        end
        if (r < 65)
        begin
            return last_removed;
        end
        return pick_element();
    endfunction

    // Offer one item, wait for it to be taken, then record its expectation
    task automatic send_request(input action_t act, input value_t val,
                                input bit typed, input rsp_t want);
        int unsigned gap;
        rsp_t        predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= val;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        predicted = apply_request(act, val);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    function automatic void check_result(rsp_t got);
        rsp_t want;
        if (pending_results.size() == 0)
        begin
            $error("result item with no request outstanding");
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
        end
        if (got.front_value !== want.front_value)
        begin
            $error("front_value: expected %h, got %h", want.front_value, got.front_value);
            error_count++;
        end
        if (got.found !== want.found)
        begin
            $error("found: expected %0b, got %0b", want.found, got.found);
            error_count++;
        end
        if (got.occupancy !== want.occupancy)
        begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
            error_count++;
        end
        if (got.is_empty !== want.is_empty)
        begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
            error_count++;
        end
    endfunction

    // Sample result items at the rising edge
    always @(posedge clk)
    begin
        rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status      = rsp_ch.status;
            got.front_value = rsp_ch.front_value;
            got.found       = rsp_ch.found;
            got.occupancy   = rsp_ch.occupancy;
            got.is_empty    = rsp_ch.is_empty;
            results_seen++;
            if (got.status == STS_FULL)
            begin
                full_refusals++;
            end
            if (got.status == STS_EMPTY)
            begin
                empty_refusals++;
            end
            if (got.found)
            begin
                search_hits++;
            end
            check_result(got);
        end
    end

    // Result side: random stalls plus a long hold-off every so often
    initial
    begin
        int unsigned stall_left;
        int unsigned next_hold_at;
        stall_left   = 0;
        next_hold_at = 40;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && results_seen >= next_hold_at)
            begin
                stall_left   = LONG_HOLD;
                next_hold_at = next_hold_at + HOLD_SPACING;
            end
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("timeout after %0d idle cycles", quiet);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        bit          grow;
        int unsigned linger;
        int unsigned r;
        action_t     act;
        value_t      val;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_ENQ;
        req_ch.value  = '0;
        clear_model();
        grow   = 1'b0;
        linger = 0;

        // Hold reset, release away from the rising edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed rows
        foreach (directed_rows[i])
        begin
            for (int k = 0; k < int'(directed_rows[i].reps); k++)
            begin
                send_request(directed_rows[i].act, directed_rows[i].val + value_t'(k),
                             directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random part: drain toward empty, then grow toward full, and so on
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            gaps_enabled = !(k >= 120 && k < 200);
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                act = ACT_SPARE;
            end
            else if (r < 14)
            begin
                act = ACT_SEARCH;
            end
            else if (r < 21)
            begin
                act = grow ? ACT_DEQ : ACT_ENQ;
            end
            else
            begin
                act = grow ? ACT_ENQ : ACT_DEQ;
            end
            case (act)
                ACT_ENQ:    val = pick_element();
                ACT_SEARCH: val = pick_search_value();
                default:    val = value_t'($urandom);
            endcase
            send_request(act, val, 1'b0, '0);

            // Linger at the limit for a few refusals, then turn around
            if (q_count == (grow ? occ_t'(DEPTH) : occ_t'(0)))
            begin
                if (linger == 0)
                begin
                    linger = $urandom_range(3, 8);
                end
                else
                begin
                    linger--;
                    if (linger == 0)
                    begin
                        grow = !grow;
                    end
                end
            end
        end
        gaps_enabled = 1'b1;
        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Wait for every outstanding result, then a short drain
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests, checked %0d results", items_sent, results_seen);
        $display("refused: %0d full, %0d empty; %0d searches matched",
                 full_refusals, empty_refusals, search_hits);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
